// File: rtl/transfer_function_color_lookup_macros.svh
// Assertion macros shared by the transfer function lookup RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef TRANSFER_FUNCTION_COLOR_LOOKUP_MACROS_SVH
`define TRANSFER_FUNCTION_COLOR_LOOKUP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle property, reset-qualified.
`define TFCL_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
// Next-cycle implication, reset-qualified.
`define TFCL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TFCL_ASSERT(lbl, clk, rstn, prop)
`define TFCL_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/tfcl_pkg.sv
// Package of the transfer function lookup: sizes, codes and payload types.
// No dependencies; used by every RTL file of the block but the assertion macro header.
`default_nettype none
package tfcl_pkg;

  localparam int MAX_CONTROLS = 16;
  localparam int ALPHA_DEPTH  = 256;
  localparam int MAP_DEPTH    = 4096;

  localparam int SLOT_W   = 4;
  localparam int AIDX_W   = 8;
  localparam int MIDX_W   = 12;
  localparam int VAL_W    = 16;
  localparam int RES_W    = 13;
  localparam int ACNT_W   = 9;
  localparam int CCNT_W   = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Divider sizing: dividend, divisor, quotient steps.
  localparam int DVD_W     = 46;
  localparam int DSR_W     = 30;
  localparam int DIV_STEPS = 21;
  localparam int DCNT_W    = 5;

  typedef enum logic [1:0] {
    CMD_WRITE_CP    = 2'd0,
    CMD_WRITE_ALPHA = 2'd1,
    CMD_LOOKUP      = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_RES   = 2'd0,
    REG_ALPHA_CNT = 2'd1,
    REG_CTRL_CNT  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]        command;
    logic [SLOT_W-1:0] slot;
    logic [VAL_W-1:0]  position;
    logic [VAL_W-1:0]  red_in;
    logic [VAL_W-1:0]  green_in;
    logic [VAL_W-1:0]  blue_in;
    logic [AIDX_W-1:0] alpha_index;
    logic [VAL_W-1:0]  alpha_in;
    logic [MIDX_W-1:0] map_index;
  } req_t;

  typedef struct packed {
    logic             valid_res;
    logic [VAL_W-1:0] red_out;
    logic [VAL_W-1:0] green_out;
    logic [VAL_W-1:0] blue_out;
    logic [VAL_W-1:0] alpha_out;
  } res_t;

  typedef struct packed {
    logic              load;
    logic              write_cp;
    logic              write_alpha;
    logic              scan_rd;
    logic [SLOT_W-1:0] scan_addr;
    logic              fdiv_start;
    logic              fetch;
    logic              prod;
    logic              div_start;
    logic              out_load;
    logic              out_zero;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CCNT_W-1:0] n_eff;
    logic              fdiv_busy;
    logic              div_busy;
  } dp_status_t;

endpackage
`default_nettype wire

// File: rtl/tfcl_if.sv
// Handshake channels of the transfer function lookup: request, result, config.
// Depends on tfcl_pkg.
`default_nettype none
interface tfcl_req_if;
  logic          valid;
  logic          ready;
  tfcl_pkg::req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface tfcl_res_if;
  logic          valid;
  logic          ready;
  tfcl_pkg::res_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface tfcl_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tfcl_pkg::CFG_IDX_W-1:0]  index;
  logic [tfcl_pkg::CFG_DATA_W-1:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/tfcl_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on tfcl_pkg.
`default_nettype none
module tfcl_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tfcl_pkg::DVD_W-1:0]    dividend_i,
  input  logic [tfcl_pkg::DSR_W-1:0]    divisor_i,
  output logic                          busy_o,
  output logic [tfcl_pkg::DIV_STEPS-1:0] quotient_o,
  output logic [tfcl_pkg::DSR_W-1:0]    remainder_o
);
  localparam int DW = tfcl_pkg::DSR_W;
  localparam int QW = tfcl_pkg::DIV_STEPS;

  logic            busy_q, busy_d;
  logic [tfcl_pkg::DCNT_W-1:0] cnt_q, cnt_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [QW-1:0]   dvd_q, dvd_d;
  logic [DW-1:0]   dsr_q, dsr_d;
  logic [DW:0]     trial;
  logic [DW:0]     diff;
  logic            ge;

  assign trial = {rem_q, dvd_q[QW-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = DW'(dividend_i[tfcl_pkg::DVD_W-1:QW]);
      dvd_d  = dividend_i[QW-1:0];
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
      dvd_d = {dvd_q[QW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == tfcl_pkg::DCNT_W'(QW - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
  end

  assign busy_o      = busy_q;
  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;
endmodule
`default_nettype wire

// File: rtl/tfcl_datapath.sv
// Datapath: config registers, control point and alpha stores, scan, dividers.
// Depends on tfcl_pkg and tfcl_div.
`default_nettype none
module tfcl_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tfcl_pkg::req_t                  req_data_i,
  input  logic                            cfg_valid_i,
  input  logic [tfcl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tfcl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                            cfg_ready_o,
  input  tfcl_pkg::ctrl_cmd_t             cmd_i,
  output tfcl_pkg::dp_status_t            status_o,
  output tfcl_pkg::res_t                  res_data_o
);
  localparam int VW = tfcl_pkg::VAL_W;

  // Configuration
  logic [tfcl_pkg::RES_W-1:0]  map_res_q;
  logic [tfcl_pkg::ACNT_W-1:0] alpha_cnt_q;
  logic [tfcl_pkg::CCNT_W-1:0] ctrl_cnt_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_res_q   <= 13'd256;
      alpha_cnt_q <= 9'd256;
      ctrl_cnt_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tfcl_pkg::REG_MAP_RES:   map_res_q   <= cfg_data_i;
        tfcl_pkg::REG_ALPHA_CNT: alpha_cnt_q <= cfg_data_i[tfcl_pkg::ACNT_W-1:0];
        tfcl_pkg::REG_CTRL_CNT:  ctrl_cnt_q  <= cfg_data_i[tfcl_pkg::CCNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [tfcl_pkg::RES_W-1:0]  r_eff;
  logic [tfcl_pkg::RES_W:0]    two_r;
  logic [tfcl_pkg::ACNT_W-1:0] a_eff, a_m1;
  logic [tfcl_pkg::AIDX_W-1:0] amax;
  logic [tfcl_pkg::CCNT_W-1:0] n_eff;
  logic                        mode_direct, mode_two;

  assign r_eff = (map_res_q == '0) ? 13'd1 : map_res_q;
  assign two_r = {r_eff, 1'b0};
  always_comb begin
    if (alpha_cnt_q == '0) begin
      a_eff = 9'd1;
    end else if (alpha_cnt_q > 9'(tfcl_pkg::ALPHA_DEPTH)) begin
      a_eff = 9'(tfcl_pkg::ALPHA_DEPTH);
    end else begin
      a_eff = alpha_cnt_q;
    end
  end
  assign a_m1  = a_eff - 9'd1;
  assign amax  = a_m1[tfcl_pkg::AIDX_W-1:0];
  assign n_eff = (ctrl_cnt_q > 5'(tfcl_pkg::MAX_CONTROLS)) ?
                 5'(tfcl_pkg::MAX_CONTROLS) : ctrl_cnt_q;
  assign mode_direct = (r_eff == {4'd0, a_eff});
  assign mode_two    = (two_r == {5'd0, a_eff});

  // Request capture
  logic [tfcl_pkg::MIDX_W-1:0] map_idx_q;
  logic signed [22:0]          nn_q, nn_d;
  logic [12:0]                 mi1;
  logic [21:0]                 nn_prod;
  logic [27:0]                 vnum;

  assign mi1     = {req_data_i.map_index, 1'b1};
  assign nn_prod = 22'(mi1) * 22'(a_eff);
  assign nn_d    = $signed({1'b0, nn_prod}) - $signed({10'd0, r_eff});
  assign vnum    = {map_idx_q, 1'b1, 15'd0};

  // Stores
  logic [63:0] cp_mem [tfcl_pkg::MAX_CONTROLS];
  logic [VW-1:0] alpha_mem [tfcl_pkg::ALPHA_DEPTH];
  logic [63:0] cp_rd_q;
  logic        eval_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.write_cp) begin
      cp_mem[req_data_i.slot] <= {req_data_i.position, req_data_i.red_in,
                                  req_data_i.green_in, req_data_i.blue_in};
    end
    if (cmd_i.scan_rd) begin
      cp_rd_q <= cp_mem[cmd_i.scan_addr];
    end
    if (cmd_i.write_alpha) begin
      alpha_mem[req_data_i.alpha_index] <= req_data_i.alpha_in;
    end
  end

  // Scan: left is the largest position below v, right the smallest at or above
  logic [VW-1:0] rd_pos;
  logic [29:0]   rd_p2r;
  logic          is_left;
  logic          left_found_q, right_found_q;
  logic [63:0]   left_q, right_q;

  assign rd_pos  = cp_rd_q[63:48];
  assign rd_p2r  = 30'(rd_pos) * 30'(two_r);
  assign is_left = rd_p2r < {2'd0, vnum};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eval_q        <= 1'b0;
      left_found_q  <= 1'b0;
      right_found_q <= 1'b0;
    end else begin
      eval_q <= cmd_i.scan_rd;
      if (cmd_i.load) begin
        left_found_q  <= 1'b0;
        right_found_q <= 1'b0;
      end else if (eval_q) begin
        if (is_left) begin
          if (!left_found_q || rd_pos > left_q[63:48]) left_found_q <= 1'b1;
        end else begin
          if (!right_found_q || rd_pos < right_q[63:48]) right_found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      map_idx_q <= req_data_i.map_index;
      nn_q      <= nn_d;
    end
    if (eval_q) begin
      if (is_left) begin
        if (!left_found_q || rd_pos > left_q[63:48]) left_q <= cp_rd_q;
      end else begin
        if (!right_found_q || rd_pos < right_q[63:48]) right_q <= cp_rd_q;
      end
    end
  end

  // Dividers
  logic [tfcl_pkg::DIV_STEPS-1:0] cq [3];
  logic [tfcl_pkg::DSR_W-1:0]     crem [3];
  logic [2:0]                     cbusy;
  logic [tfcl_pkg::DIV_STEPS-1:0] aq;
  logic [tfcl_pkg::DSR_W-1:0]     arem;
  logic                           abusy;
  logic [tfcl_pkg::DVD_W-1:0]     prod_q [3];
  logic [29:0]                    num_q, den_q;
  logic [29:0]                    aprod_q;
  logic [tfcl_pkg::DVD_W-1:0]     a_dvd;

  for (genvar g = 0; g < 3; g++) begin : g_cdiv
    tfcl_div u_div (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .start_i     (cmd_i.div_start),
      .dividend_i  (prod_q[g]),
      .divisor_i   (den_q),
      .busy_o      (cbusy[g]),
      .quotient_o  (cq[g]),
      .remainder_o (crem[g])
    );
  end

  // The alpha divider first finds the floor index, then the weighted step.
  assign a_dvd = cmd_i.div_start ? tfcl_pkg::DVD_W'(aprod_q) :
                 (nn_q[22] ? '0 : tfcl_pkg::DVD_W'(nn_q[20:0]));

  tfcl_div u_div_alpha (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.fdiv_start | cmd_i.div_start),
    .dividend_i  (a_dvd),
    .divisor_i   (30'(two_r)),
    .busy_o      (abusy),
    .quotient_o  (aq),
    .remainder_o (arem)
  );

  assign status_o.n_eff     = n_eff;
  assign status_o.fdiv_busy = abusy;
  assign status_o.div_busy  = abusy | (|cbusy);

  // Alpha indices
  logic [12:0]                 i13, i2, amax13;
  logic [tfcl_pkg::AIDX_W-1:0] af_idx, ac_idx;
  logic                        a_eq;

  assign i13    = {1'b0, map_idx_q};
  assign i2     = {map_idx_q, 1'b0};
  assign amax13 = {5'd0, amax};

  always_comb begin
    a_eq   = 1'b1;
    af_idx = amax;
    ac_idx = amax;
    if (mode_direct) begin
      af_idx = (i13 > amax13) ? amax : i13[7:0];
      ac_idx = af_idx;
    end else if (mode_two) begin
      af_idx = (i2 > amax13) ? amax : i2[7:0];
      ac_idx = af_idx;
    end else if (nn_q[22]) begin
      af_idx = '0;
      ac_idx = '0;
    end else if (aq < {13'd0, amax}) begin
      af_idx = aq[7:0];
      ac_idx = aq[7:0] + 8'd1;
      a_eq   = 1'b0;
    end
  end

  logic [VW-1:0] a_f_q, a_c_q;
  logic          a_eq_q;
  logic [13:0]   wn_q;
  logic [VW-1:0] lpos, rpos;
  logic [29:0]   lp2r;
  logic [VW-1:0] cl [3];
  logic [VW-1:0] cr [3];
  logic [2:0]    cdown;
  logic [VW-1:0] cdiff [3];
  logic          adown;
  logic [VW-1:0] adiff;

  assign lpos = left_q[63:48];
  assign rpos = right_q[63:48];
  assign lp2r = 30'(lpos) * 30'(two_r);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cl[c]    = left_q[47 - 16*c -: 16];
      cr[c]    = right_q[47 - 16*c -: 16];
      cdown[c] = cr[c] < cl[c];
      cdiff[c] = cdown[c] ? (cl[c] - cr[c]) : (cr[c] - cl[c]);
    end
  end
  assign adown = a_c_q < a_f_q;
  assign adiff = adown ? (a_f_q - a_c_q) : (a_c_q - a_f_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) begin
      a_f_q  <= alpha_mem[af_idx];
      a_c_q  <= alpha_mem[ac_idx];
      a_eq_q <= a_eq;
      wn_q   <= arem[13:0];
      num_q  <= {2'd0, vnum} - lp2r;
      den_q  <= 30'(two_r) * 30'(rpos - lpos);
    end
    if (cmd_i.prod) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[c] <= 46'(cdiff[c]) * 46'(num_q);
      end
      aprod_q <= 30'(adiff) * 30'(wn_q);
    end
  end

  // Final values: truncate toward the lower result
  logic [VW-1:0] cval [3];
  logic [VW-1:0] aval;
  logic [VW-1:0] astep;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (!left_found_q) begin
        cval[c] = cr[c];
      end else if (!right_found_q) begin
        cval[c] = cl[c];
      end else if (cdown[c]) begin
        cval[c] = cl[c] - (cq[c][VW-1:0] + {15'd0, |crem[c]});
      end else begin
        cval[c] = cl[c] + cq[c][VW-1:0];
      end
    end
  end

  assign astep = adown ? (aq[VW-1:0] + {15'd0, |arem}) : aq[VW-1:0];
  assign aval  = a_eq_q ? a_f_q : (adown ? (a_f_q - astep) : (a_f_q + astep));

  tfcl_pkg::res_t out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (cmd_i.out_zero) begin
        out_q <= '0;
      end else begin
        out_q.valid_res <= 1'b1;
        out_q.red_out   <= cval[0];
        out_q.green_out <= cval[1];
        out_q.blue_out  <= cval[2];
        out_q.alpha_out <= aval;
      end
    end
  end

  assign res_data_o = out_q;
endmodule
`default_nettype wire

// File: rtl/tfcl_ctrl.sv
// Controller: sequences writes, control point scan, divisions and result.
// Depends on tfcl_pkg and the assertion macro header.
`default_nettype none
`include "transfer_function_color_lookup_macros.svh"
module tfcl_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  input  logic [1:0]           req_command_i,
  input  logic                 res_ready_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  output tfcl_pkg::ctrl_cmd_t  cmd_o,
  input  tfcl_pkg::dp_status_t status_i
);
  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_SCAN     = 9'b000000010,
    ST_SCAN_END = 9'b000000100,
    ST_WAIT_F   = 9'b000001000,
    ST_FETCH    = 9'b000010000,
    ST_PROD     = 9'b000100000,
    ST_DIV_GO   = 9'b001000000,
    ST_DIV_WAIT = 9'b010000000,
    ST_RESULT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [tfcl_pkg::SLOT_W-1:0] cnt_q, cnt_d;
  logic zero_q, zero_d;
  logic out_valid_q, out_valid_d;
  logic accept;
  logic [tfcl_pkg::CCNT_W-1:0] n_m1;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = req_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign n_m1        = status_i.n_eff - 5'd1;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    zero_d  = zero_q;
    out_valid_d = out_valid_q & ~res_ready_i;
    cmd_o   = '0;
    cmd_o.scan_addr = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          zero_d     = 1'b1;
          state_d    = ST_RESULT;
          if (req_command_i == tfcl_pkg::CMD_WRITE_CP) begin
            cmd_o.write_cp = 1'b1;
          end else if (req_command_i == tfcl_pkg::CMD_WRITE_ALPHA) begin
            cmd_o.write_alpha = 1'b1;
          end else if (req_command_i == tfcl_pkg::CMD_LOOKUP &&
                       status_i.n_eff != '0) begin
            zero_d  = 1'b0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_rd    = 1'b1;
        cmd_o.fdiv_start = (cnt_q == '0);
        if ({1'b0, cnt_q} == n_m1) begin
          state_d = ST_SCAN_END;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_SCAN_END: state_d = ST_WAIT_F;
      ST_WAIT_F: begin
        if (!status_i.fdiv_busy) state_d = ST_FETCH;
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = ST_PROD;
      end
      ST_PROD: begin
        cmd_o.prod = 1'b1;
        state_d    = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!status_i.div_busy) state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || res_ready_i) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_zero = zero_q;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      zero_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      zero_q      <= zero_d;
      out_valid_q <= out_valid_d;
    end
  end

  `TFCL_ASSERT_NEXT(a_accept_blocks, clk_i, rst_ni, accept, !in_ready_o)
  `TFCL_ASSERT(a_scan_in_range, clk_i, rst_ni, cmd_o.scan_rd |-> ({1'b0, cmd_o.scan_addr} < status_i.n_eff))
  `TFCL_ASSERT_NEXT(a_div_runs, clk_i, rst_ni, cmd_o.div_start, status_i.div_busy)
  `TFCL_ASSERT(a_no_overwrite, clk_i, rst_ni, cmd_o.out_load |-> (!out_valid_q || res_ready_i))
endmodule
`default_nettype wire

// File: rtl/transfer_function_color_lookup.sv
// Top level of the transfer function lookup: controller plus datapath.
// Depends on tfcl_pkg, tfcl_if, tfcl_ctrl and tfcl_datapath.
// Writes, unknown commands and lookups with no controls go from accept straight to the result.
// Lookup: for any control count up to 16 the time is set by the 21-step alpha index
// division (started with the scan, outlasting it) plus fetch, products and the 21-step divide.
// One request in flight; the next is accepted once the result is registered.
// Reset: map_resolution 256, alpha_count 256, control_count 0; stores keep no reset.
`default_nettype none
module transfer_function_color_lookup (
  input  logic        clk_i,
  input  logic        rst_ni,
  tfcl_req_if.sink    req_i,
  tfcl_res_if.source  res_o,
  tfcl_cfg_if.sink    cfg_i
);
  // Commands from the controller and status back from the datapath.
  tfcl_pkg::ctrl_cmd_t  cmd;
  tfcl_pkg::dp_status_t status;
  logic                 in_ready;
  logic                 out_valid;

  // Sequencer: holds one request at a time and advances through scan,
  // index division, fetch, products and interpolation division.
  tfcl_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .req_command_i (req_i.data.command),
    .res_ready_i   (res_o.ready),
    .in_ready_o    (in_ready),
    .out_valid_o   (out_valid),
    .cmd_o         (cmd),
    .status_i      (status)
  );

  // Arithmetic, stores and the result register.
  tfcl_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_data_i  (req_i.data),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .cfg_ready_o (cfg_i.ready),
    .cmd_i       (cmd),
    .status_o    (status),
    .res_data_o  (res_o.data)
  );

  assign req_i.ready = in_ready;
  assign res_o.valid = out_valid;
endmodule
`default_nettype wire
